/* rtl/assert_macros.svh */
// Assertion macros for the checker file, msort_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define CHK_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// Next-cycle implication, ignored while reset is high.
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

/* rtl/msort_pkg.sv */
// Types and constants for the merge sorter.
// No dependencies.
package msort_pkg;

   localparam int VALUE_W          = 32;
   localparam int MAX_ELEMENTS_DEF = 64;

   typedef logic signed [VALUE_W-1:0] value_type;

   localparam value_type VALUE_ZERO = '0;

   // per-cycle command to every cell of the chain
   typedef struct packed {
      logic insert;   // place the incoming word in order
      logic shift;    // move every word one cell towards the head
   } cell_ctrl_type;

endpackage

/* rtl/msort_if.sv */
// Valid/ready channel interfaces for the request and response words.
// Depends on msort_pkg.
interface msort_req_if;
   import msort_pkg::*;
   logic      valid;
   logic      ready;
   value_type value;
   logic      last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface msort_rsp_if;
   import msort_pkg::*;
   logic      valid;
   logic      ready;
   value_type sorted_value;
   logic      last_res;
   logic      dropped;

   modport source (output valid, output sorted_value, output last_res, output dropped,
                   input ready);
   modport sink   (input valid, input sorted_value, input last_res, input dropped,
                   output ready);
endinterface

/* rtl/msort_cell.sv */
// One cell of the sorting chain: holds one word and its occupied flag.
// Depends on msort_pkg.
module msort_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  msort_pkg::cell_ctrl_type ctrl,
   input  msort_pkg::value_type     new_value,
   input  msort_pkg::value_type     prev_value,
   input  logic                     prev_occ,
   input  logic                     prev_gt,
   input  msort_pkg::value_type     next_value,
   input  logic                     next_occ,
   output msort_pkg::value_type     cur_value,
   output logic                     cur_occ,
   output logic                     cur_gt
);
   import msort_pkg::*;

   value_type value_ff, value_in;
   logic      occ_ff, occ_in;

   // empty cells count as greater; strict compare keeps equal words in arrival order
   assign cur_gt    = !occ_ff || (value_ff > new_value);
   assign cur_value = value_ff;
   assign cur_occ   = occ_ff;

   always_comb begin
      value_in = value_ff;
      occ_in   = occ_ff;
      if (ctrl.insert && cur_gt) begin
         if (prev_gt) begin
            value_in = prev_value;
            occ_in   = prev_occ;
         end else begin
            value_in = new_value;
            occ_in   = 1'b1;
         end
      end else if (ctrl.shift) begin
         value_in = next_value;
         occ_in   = next_occ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

/* rtl/merge_sorter.sv */
// merge_sorter: sorts a run of signed words into ascending order.
// Load: one request word per cycle, each placed in order on arrival by the cell chain.
// After the last word: first response word on the next cycle, then one word per cycle
// while rsp ready is high. The next run is taken the cycle after its final response
// word is accepted. Synchronous reset empties the chain and returns to loading;
// stored words keep no reset.
module merge_sorter #(
   parameter int MAX_ELEMENTS = msort_pkg::MAX_ELEMENTS_DEF
) (
   input logic         clock,
   input logic         reset,
   msort_req_if.sink   req_chan,
   msort_rsp_if.source rsp_chan
);
   import msort_pkg::*;

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      overflow_ff, overflow_in;

   value_type     cell_value [MAX_ELEMENTS];
   logic          cell_occ   [MAX_ELEMENTS];
   logic          cell_gt    [MAX_ELEMENTS];
   cell_ctrl_type ctrl;

   logic req_acc, rsp_acc, full, final_word;

   // Chain kept sorted with cell 0 smallest; the last cell holding a word means full.
   assign full       = cell_occ[MAX_ELEMENTS-1];
   assign final_word = !cell_occ[1];

   assign req_chan.ready = (state_ff == ST_LOAD);
   assign req_acc        = req_chan.valid && req_chan.ready;

   // Head cell is the response register: its word is shown while draining.
   assign rsp_chan.valid        = (state_ff == ST_DRAIN) && cell_occ[0];
   assign rsp_chan.sorted_value = cell_value[0];
   assign rsp_chan.last_res     = final_word;
   assign rsp_chan.dropped      = overflow_ff;
   assign rsp_acc               = rsp_chan.valid && rsp_chan.ready;

   // A word arriving with the chain full is dropped and marks the run.
   assign ctrl.insert = req_acc && !full;
   assign ctrl.shift  = rsp_acc;

   always_comb begin
      state_in    = state_ff;
      overflow_in = overflow_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_acc && full) begin
               overflow_in = 1'b1;
            end
            if (req_acc && req_chan.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_acc && final_word) begin
               state_in    = ST_LOAD;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in    = ST_LOAD;
            overflow_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         overflow_ff <= overflow_in;
      end
   end

   // The cell chain: each cell sees its left neighbour for insertion and its
   // right neighbour for draining. The chain ends read as empty.
   for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      value_type prev_value, next_value;
      logic      prev_occ, prev_gt, next_occ;

      if (i == 0) begin : g_head
         assign prev_value = VALUE_ZERO;
         assign prev_occ   = 1'b0;
         assign prev_gt    = 1'b0;
      end else begin : g_body
         assign prev_value = cell_value[i-1];
         assign prev_occ   = cell_occ[i-1];
         assign prev_gt    = cell_gt[i-1];
      end

      if (i == MAX_ELEMENTS - 1) begin : g_tail
         assign next_value = VALUE_ZERO;
         assign next_occ   = 1'b0;
      end else begin : g_mid
         assign next_value = cell_value[i+1];
         assign next_occ   = cell_occ[i+1];
      end

      msort_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_value  (req_chan.value),
         .prev_value (prev_value),
         .prev_occ   (prev_occ),
         .prev_gt    (prev_gt),
         .next_value (next_value),
         .next_occ   (next_occ),
         .cur_value  (cell_value[i]),
         .cur_occ    (cell_occ[i]),
         .cur_gt     (cell_gt[i])
      );
   end

endmodule

/* rtl/msort_checker.sv */
// Port-level checks for merge_sorter, attached by bind.
// Depends on msort_pkg and assert_macros.svh.
`include "assert_macros.svh"

module msort_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 req_last,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_last_res,
   input msort_pkg::value_type rsp_sorted_value
);
   import msort_pkg::*;

   // no word taken while a sorted run is still going out
   `CHK_SAME(no_load_in_drain, clock, reset, rsp_valid, !req_ready)
   // a closing word always yields output on the next cycle
   `CHK_NEXT(drain_follows_last, clock, reset, req_valid && req_ready && req_last, rsp_valid)
   // output stops after the final word of a run is taken
   `CHK_NEXT(drain_ends, clock, reset, rsp_valid && rsp_ready && rsp_last_res, !rsp_valid)
   // stalled response word holds
   `CHK_NEXT(rsp_hold, clock, reset, rsp_valid && !rsp_ready,
             rsp_valid && $stable(rsp_sorted_value))

endmodule

bind merge_sorter msort_checker u_msort_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_last         (req_chan.last),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_last_res     (rsp_chan.last_res),
   .rsp_sorted_value (rsp_chan.sorted_value)
);

/* sim/tb_merge_sorter.sv */
// Self-checking testbench for merge_sorter: drives runs of signed words and checks each
// sorted response word against a built-in predictor. Depends on msort_pkg, msort_if and
// the merge_sorter RTL.
module tb_merge_sorter;
   timeunit 1ns;
   timeprecision 1ps;

   import msort_pkg::*;

   localparam int MAX_ELEMENTS = MAX_ELEMENTS_DEF;
   localparam int ITEM_TARGET  = 310;

   // Longest legitimate quiet spell: the receiver's long hold-off plus worst-case gaps
   // on each side and the response delay. Taken several times over.
   localparam int HOLD_AT      = 100;    // response word at which the long hold-off starts
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_LIMIT   = 2000;
   // After the last expected word: room for a spurious full run to show up.
   localparam int TAIL_CYCLES  = 2 * MAX_ELEMENTS + 16;

   localparam value_type VAL_MIN = 32'h8000_0000;
   localparam value_type VAL_MAX = 32'h7FFF_FFFF;
   localparam value_type VAL_ONES = 32'hFFFF_FFFF;

   typedef struct packed {
      value_type value;
      logic      last;
      logic      dropped;
   } rsp_word_type;

   // typed = 1: a one-word run whose response is simply the word itself
   typedef struct packed {
      value_type value;
      logic      last;
      logic      typed;
      value_type want;
   } stim_row_type;

   localparam int N_ROWS = 20;
   localparam stim_row_type DIRECTED_ROWS [N_ROWS] = '{
      // one-word runs at the extremes: the word comes straight back, last set
      '{VAL_MIN,      1'b1, 1'b1, VAL_MIN},
      '{VAL_MAX,      1'b1, 1'b1, VAL_MAX},
      '{32'h0,        1'b1, 1'b1, 32'h0},
      '{VAL_ONES,     1'b1, 1'b1, VAL_ONES},
      // mixed extremes, sign boundary either side of zero
      '{VAL_MAX,      1'b0, 1'b0, 32'h0},
      '{VAL_MIN,      1'b0, 1'b0, 32'h0},
      '{32'h0,        1'b0, 1'b0, 32'h0},
      '{VAL_ONES,     1'b0, 1'b0, 32'h0},
      '{32'h1,        1'b1, 1'b0, 32'h0},
      // already in order
      '{32'hFFFF_FFFD, 1'b0, 1'b0, 32'h0},
      '{32'hFFFF_FFFE, 1'b0, 1'b0, 32'h0},
      '{VAL_ONES,     1'b0, 1'b0, 32'h0},
      '{32'h5,        1'b1, 1'b0, 32'h0},
      // reversed, with equal neighbours
      '{32'h7,        1'b0, 1'b0, 32'h0},
      '{32'h7,        1'b0, 1'b0, 32'h0},
      '{32'h3,        1'b0, 1'b0, 32'h0},
      '{32'h3,        1'b0, 1'b0, 32'h0},
      '{32'hFFFF_FFF8, 1'b1, 1'b0, 32'h0},
      // alternating bit patterns, negative one first
      '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
      '{32'h5555_5555, 1'b1, 1'b0, 32'h0}
   };

   logic clock;
   logic reset;

   msort_req_if req_bus ();
   msort_rsp_if rsp_bus ();

   merge_sorter #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // predictor state: the current run kept in ascending order as words arrive
   value_type    run_held [$];
   logic         run_cut;
   rsp_word_type run_output [$];   // words released by the latest request word
   rsp_word_type sorted_due [$];   // response words still owed by the block

   int  mismatches;
   int  words_sent;
   int  rsp_words;
   int  idle_cycles;
   bit  req_calm;
   bit  rsp_calm;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Takes one accepted request word. A word is kept only while the run has room;
   // inserting after every held word that is not greater keeps equal words in arrival
   // order. On the last word the whole run is released and the run state cleared.
   function automatic void absorb_word(value_type v, logic l);
      int           slot;
      rsp_word_type w;
      run_output.delete();
      if (run_held.size() < MAX_ELEMENTS) begin
         slot = run_held.size();
         while (slot > 0 && run_held[slot-1] > v) slot--;
         run_held.insert(slot, v);
      end else begin
         run_cut = 1'b1;   // full: word dropped, last one included
      end
      if (l) begin
         foreach (run_held[k]) begin
            w.value   = run_held[k];
            w.last    = (k == run_held.size() - 1);
            w.dropped = run_cut;
            run_output.push_back(w);
         end
         run_held.delete();
         run_cut = 1'b0;
      end
   endfunction

   // Half full-range words, with a share near the extremes and a share of small
   // values so that runs hold plenty of equal words.
   function automatic value_type rand_value();
      case ($urandom_range(0, 5))
         0:       return value_type'(32'h8000_0000 + $urandom_range(0, 3));
         1:       return value_type'(32'h7FFF_FFFF - $urandom_range(0, 3));
         2:       return value_type'(int'($urandom_range(0, 8)) - 4);
         default: return value_type'($urandom());
      endcase
   endfunction

   function automatic int draw_gap(inout bit calm);
      if ($urandom_range(0, 15) == 0) calm = ~calm;
      return calm ? 0 : $urandom_range(0, 14);
   endfunction

   // Called just after a falling edge; returns just after the falling edge that follows
   // acceptance. valid is only ever assigned once per time step.
   task automatic send_word(value_type v, logic l, logic typed, value_type want);
      int           gap;
      rsp_word_type w;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      req_bus.last  <= l;
      do @(posedge clock); while (!req_bus.ready);
      absorb_word(v, l);
      if (typed) begin
         w.value   = want;
         w.last    = 1'b1;
         w.dropped = 1'b0;
         sorted_due.push_back(w);
      end else begin
         foreach (run_output[k]) sorted_due.push_back(run_output[k]);
      end
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_run(int len);
      for (int i = 0; i < len; i++) send_word(rand_value(), i == len - 1, 1'b0, 32'h0);
   endtask

   // stimulus
   initial begin
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      req_bus.last  = 1'b0;
      run_cut       = 1'b0;
      mismatches    = 0;
      words_sent    = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED_ROWS[r])
         send_word(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].last,
                   DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

      // capacity cases: exactly full, last word arriving on a full store, several cut
      send_run(MAX_ELEMENTS);
      send_run(MAX_ELEMENTS + 1);
      send_run(MAX_ELEMENTS + 4);

      // bulk: mostly short runs, the odd medium one
      while (words_sent < ITEM_TARGET)
         send_run(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12));
      req_bus.valid <= 1'b0;

      while (sorted_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && sorted_due.size() == 0) begin
         $display("tb_merge_sorter: done, clean");
      end else begin
         $display("tb_merge_sorter: done, errors");
      end
      $finish;
   end

   // response side: random stalls per word, plus one long hold-off while the sender
   // keeps offering, so the block backs up onto its input
   initial begin
      int           stall;
      rsp_word_type got;
      rsp_word_type want;
      rsp_bus.ready = 1'b0;
      rsp_words     = 0;
      do @(negedge clock); while (reset);
      forever begin
         stall = draw_gap(rsp_calm);
         if (rsp_words == HOLD_AT) stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         got.value   = rsp_bus.sorted_value;
         got.last    = rsp_bus.last_res;
         got.dropped = rsp_bus.dropped;
         rsp_words++;
         if (sorted_due.size() == 0) begin
            $error("unexpected response word: sorted_value %0d", got.value);
            mismatches++;
         end else begin
            want = sorted_due.pop_front();
            if (got.value !== want.value) begin
               $error("sorted_value: expected %0d, got %0d", want.value, got.value);
               mismatches++;
            end
            if (got.last !== want.last) begin
               $error("last_res: expected %0b, got %0b", want.last, got.last);
               mismatches++;
            end
            if (got.dropped !== want.dropped) begin
               $error("dropped: expected %0b, got %0b", want.dropped, got.dropped);
               mismatches++;
            end
         end
         @(negedge clock);
      end
   end

   // watchdog: too long without any word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_merge_sorter: done, errors");
         $finish;
      end
   end

   initial idle_cycles = 0;

endmodule

/* filelist.f */
+incdir+rtl
rtl/msort_pkg.sv
rtl/msort_if.sv
rtl/msort_cell.sv
rtl/merge_sorter.sv
rtl/msort_checker.sv
sim/tb_merge_sorter.sv
